// ----- design/cons_cell_free_list_allocator_unit_defines.svh -----
// Assertion macros for the cons cell allocator.
// Depends on nothing; included by the top level only.
`ifndef CONS_CELL_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`define CONS_CELL_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CCFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cons cell allocator: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define CCFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cons cell allocator: next-cycle check failed");

`endif

// ----- design/ccfa_pkg.sv -----
// Shared constants, command codes and control structs of the cons cell allocator.
// Used by the controller and the top level; no dependencies.
package ccfa_pkg;

  localparam int CELL_COUNT = 8192;
  localparam int WORD_BITS  = 32;
  localparam int CELL_BITS  = $clog2(CELL_COUNT);
  localparam int FRESH_BITS = CELL_BITS + 1;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_HEAD  = 2'd1,
    CMD_TAIL  = 2'd2,
    CMD_FREE  = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RESP = 1'b1
  } state_t;

  // Write and read request to both cell memories (they share addresses).
  typedef struct packed {
    logic                 we;
    logic [CELL_BITS-1:0] waddr;
    logic [WORD_BITS-1:0] whead;
    logic [WORD_BITS-1:0] wtail;
    logic                 re;
    logic [CELL_BITS-1:0] raddr;
  } mem_req_t;

  // Finished result offered to the output register.
  typedef struct packed {
    logic                 valid;
    logic [WORD_BITS-1:0] read_word;
    logic [CELL_BITS-1:0] new_cell;
    logic                 status;
  } rsp_t;

endpackage

// ----- design/cons_cell_free_list_allocator_unit.sv -----
// Cons cell store with a free list: allocate, read head, read tail, free.
// A word is accepted in ST_IDLE, where the cell memories are read; in ST_RESP its result goes to the output register.
// A new command is accepted only after the last one's result has gone to the output register.
// Reset (rst_n, synchronous, active low) empties the free list and sets the fresh counter
// to one; the cell memories are not cleared and hold nothing defined until written.
// Depends on ccfa_pkg, ccfa_ram, ccfa_ctrl and the defines header.
`include "cons_cell_free_list_allocator_unit_defines.svh"

module cons_cell_free_list_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // cell_ref[12:0], head_word[44:13], tail_word[76:45], zero
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // read_word[31:0], new_cell[44:32], zero
  output logic [0:0]  out_tuser   // status[0]
);
  import ccfa_pkg::*;

  // Every command goes through the controller in two steps. In the accept
  // cycle it issues one read and at most one write to the head and tail
  // memories: a successful allocate writes its cell (fresh or popped) and, when
  // popping, reads the old head word of that cell, which is the free-list link;
  // a valid free writes the link to the old top and a nil tail; a read fetches
  // the cell. In the next cycle the read data is valid; the result goes to the
  // output register when free; it may wait there while the next word is accepted.

  mem_req_t             mem_req;
  rsp_t                 rsp;
  logic [WORD_BITS-1:0] head_q;
  logic [WORD_BITS-1:0] tail_q;
  logic                 rsp_take;

  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] out_word_r;
  logic [CELL_BITS-1:0] out_cell_r;
  logic                 out_status_r;

  ccfa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(CELL_COUNT)
  ) u_head_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr),
    .wdata(mem_req.whead),
    .re   (mem_req.re),
    .raddr(mem_req.raddr),
    .rdata(head_q)
  );

  ccfa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(CELL_COUNT)
  ) u_tail_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr),
    .wdata(mem_req.wtail),
    .re   (mem_req.re),
    .raddr(mem_req.raddr),
    .rdata(tail_q)
  );

  ccfa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_cmd  (cmd_t'(in_tuser)),
    .in_ref  (in_tdata[12:0]),
    .in_head (in_tdata[44:13]),
    .in_tail (in_tdata[76:45]),
    .mem_req (mem_req),
    .head_q  (head_q),
    .tail_q  (tail_q),
    .rsp_take(rsp_take),
    .rsp     (rsp)
  );

  // The output register takes a new result when it is empty or being drained.
  assign rsp_take = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp.valid && rsp_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.valid && rsp_take) begin
      out_word_r   <= rsp.read_word;
      out_cell_r   <= rsp.new_cell;
      out_status_r <= rsp.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cell_r, out_word_r};
  assign out_tuser  = out_status_r;

  // A failed allocate reports no cell and no word.
  `CCFA_ASSERT_NOW(a_fail_empty, clk, rst_n, out_tvalid && out_tuser[0],
                   out_tdata[44:32] == 13'd0 && out_tdata[31:0] == 32'd0)
  // A granted cell never comes with a read word.
  `CCFA_ASSERT_NOW(a_cell_no_word, clk, rst_n, out_tvalid && out_tdata[44:32] != 13'd0,
                   out_tdata[31:0] == 32'd0 && !out_tuser[0])
  // Only one command is in flight: an accepted word closes the input until its result is taken.
  `CCFA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready)

endmodule

// ----- design/ccfa_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Read-first: a read of the address being written returns the old data.
module ccfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ----- design/ccfa_ctrl.sv -----
// Command sequencer: free-list top, fresh-cell counter and memory requests.
// Depends on ccfa_pkg; drives the two cell memories instantiated at the top level.
module ccfa_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ccfa_pkg::cmd_t                 in_cmd,
  input  logic [ccfa_pkg::CELL_BITS-1:0] in_ref,
  input  logic [ccfa_pkg::WORD_BITS-1:0] in_head,
  input  logic [ccfa_pkg::WORD_BITS-1:0] in_tail,
  output ccfa_pkg::mem_req_t             mem_req,
  input  logic [ccfa_pkg::WORD_BITS-1:0] head_q,
  input  logic [ccfa_pkg::WORD_BITS-1:0] tail_q,
  input  logic                           rsp_take,
  output ccfa_pkg::rsp_t                 rsp
);
  import ccfa_pkg::*;

  state_t                state_r, state_nxt;
  logic [CELL_BITS-1:0]  top_r, top_nxt;
  logic [FRESH_BITS-1:0] fresh_r, fresh_nxt;

  cmd_t                  cmd_r, cmd_nxt;
  logic [CELL_BITS-1:0]  cell_r, cell_nxt;
  logic                  fail_r, fail_nxt;
  logic                  pop_r, pop_nxt;
  logic                  rdok_r, rdok_nxt;

  logic                  ref_ok;
  logic                  accept;

  // A cell number names a real, non-nil cell.
  assign ref_ok = (in_ref != '0) &&
                  ({1'b0, in_ref} < FRESH_BITS'(CELL_COUNT));
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    top_nxt   = top_r;
    fresh_nxt = fresh_r;
    cmd_nxt   = cmd_r;
    cell_nxt  = cell_r;
    fail_nxt  = fail_r;
    pop_nxt   = pop_r;
    rdok_nxt  = rdok_r;

    mem_req       = '0;
    mem_req.re    = accept;
    mem_req.raddr = (in_cmd == CMD_ALLOC) ? top_r : in_ref;

    rsp           = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_cmd;
          cell_nxt  = '0;
          fail_nxt  = 1'b0;
          pop_nxt   = 1'b0;
          rdok_nxt  = 1'b0;
          state_nxt = ST_RESP;
          case (in_cmd)
            CMD_ALLOC: begin
              if (top_r != '0) begin
                // Pop: the link sits in the popped cell's head word and is
                // fetched by this cycle's read before the write lands.
                cell_nxt = top_r;
                pop_nxt  = 1'b1;
              end else if (fresh_r < FRESH_BITS'(CELL_COUNT)) begin
                cell_nxt  = fresh_r[CELL_BITS-1:0];
                fresh_nxt = fresh_r + FRESH_BITS'(1);
              end else begin
                fail_nxt = 1'b1;
              end
              mem_req.we    = !fail_nxt;
              mem_req.waddr = cell_nxt;
              mem_req.whead = in_head;
              mem_req.wtail = in_tail;
            end
            CMD_HEAD, CMD_TAIL: begin
              rdok_nxt = ref_ok;
            end
            CMD_FREE: begin
              if (ref_ok) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = in_ref;
                mem_req.whead = WORD_BITS'(top_r);
                mem_req.wtail = '0;
                top_nxt       = in_ref;
              end
            end
            default: begin
              rdok_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_RESP: begin
        rsp.valid     = 1'b1;
        rsp.new_cell  = cell_r;
        rsp.status    = fail_r;
        if (rdok_r) begin
          rsp.read_word = (cmd_r == CMD_HEAD) ? head_q : tail_q;
        end
        if (rsp_take) begin
          state_nxt = ST_IDLE;
          if (pop_r) begin
            // A link that is no valid cell number empties the list.
            top_nxt = (head_q < WORD_BITS'(CELL_COUNT)) ? head_q[CELL_BITS-1:0] : '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      top_r   <= '0;
      fresh_r <= FRESH_BITS'(1);
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    cell_r <= cell_nxt;
    fail_r <= fail_nxt;
    pop_r  <= pop_nxt;
    rdok_r <= rdok_nxt;
  end

endmodule
